### src/bhs_pkg.sv
package bhs_pkg;

  // Block sizing.
  localparam int CHANNELS = 2;
  localparam int PASSES   = 2;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PASS_W   = (PASSES > 1) ? $clog2(PASSES) : 1;

  // Field and datapath widths.
  localparam int SMP_W     = 24;
  localparam int COEF_W    = 32;
  localparam int GAIN_W    = 16;
  localparam int Q24_W     = 32;
  localparam int OP_A_W    = 33;
  localparam int OP_B_W    = 32;
  localparam int PROD_W    = OP_A_W + OP_B_W;
  localparam int ACC_W     = 48;
  localparam int QUO_W     = 23;
  localparam int CFG_IDX_W = 3;

  // Product alignment: Q.35 gain product down to Q8.24, and Q.52 down to Q.32.
  localparam int GAIN_SHIFT = 11;
  localparam int PROD_SHIFT = 20;
  localparam int SUM_SHIFT  = 8;

  // History clamp at +-100.0 in Q8.24.
  localparam logic signed [Q24_W-1:0] HIST_MAX = 32'sd1677721600;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A1    = 3'd0,
    REG_COEF_A2    = 3'd1,
    REG_COEF_A3    = 3'd2,
    REG_COEF_B1    = 3'd3,
    REG_COEF_B2    = 3'd4,
    REG_DRIVE_GAIN = 3'd5
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_XCAP,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_SUM,
    ST_UPD,
    ST_DIV,
    ST_OUT
  } state_t;

  // Accumulator control for the shared multiply unit.
  typedef struct packed {
    logic acc_load;
    logic acc_add;
  } mac_ctl_t;

endpackage

### src/biquad_highpass_softclip.sv
// Highpass biquad with drive and soft clip. Each input item carries a Q1.23
// sample and a channel number; the sample is scaled by drive_gain and then
// run through the second-order recursion PASSES times against that channel's
// output history, and the highpass value of the last pass is soft clipped to
// hp/(1+|hp|). From one acceptance to the earliest next one an item runs
// through these steps: acceptance, the gain product on the shared 33x32
// multiplier, per pass its three products, the 23 steps of the radix-2
// divider for the soft clip and its report, and the load of the output
// register. The finished result waits in the output register, so the next
// item is taken while it is held; a result still held when the next one is
// finished stalls the sequencer until it leaves. Coefficients are to be
// written only while idle; the user is bound to this, the block does not enforce it.
module biquad_highpass_softclip (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,   // [23:0] in_sample
  input  logic [0:0]                        in_tuser,   // [0] channel
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [23:0]                       out_tdata,  // [23:0] out_sample
  output logic [0:0]                        out_tuser,  // [0] out_channel
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [bhs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_wdata
);

  localparam int CW = bhs_pkg::CH_IDX_W;
  localparam int QW = bhs_pkg::Q24_W;

  bhs_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [bhs_pkg::COEF_W-1:0] coef_a1_r, coef_a2_r, coef_a3_r, coef_b1_r, coef_b2_r;
  logic [bhs_pkg::GAIN_W-1:0]        drive_gain_r;

  // Per-item registers.
  logic signed [bhs_pkg::SMP_W-1:0]  smp_r;
  logic                              ch_in_r;
  logic [CW-1:0]                     ch_idx_r;
  logic [CW-1:0]                     ch_idx_nxt;
  logic signed [QW-1:0]              x_r;
  logic signed [QW-1:0]              hp_r;
  logic [bhs_pkg::PASS_W-1:0]        pass_r;
  logic                              last_pass;

  // Channel history.
  logic signed [QW-1:0] hist_one_r [bhs_pkg::CHANNELS];
  logic signed [QW-1:0] hist_two_r [bhs_pkg::CHANNELS];

  // Output register.
  logic                              out_tvalid_r;
  logic [23:0]                       out_tdata_r;
  logic                              out_tuser_r;

  // Shared unit connections.
  logic signed [bhs_pkg::OP_A_W-1:0] op_a;
  logic signed [bhs_pkg::OP_B_W-1:0] op_b;
  bhs_pkg::mac_ctl_t                 mac_ctl;
  logic signed [bhs_pkg::PROD_W-1:0] prod;
  logic signed [bhs_pkg::ACC_W-1:0]  acc;
  logic                              div_start;
  logic                              div_done;
  logic [bhs_pkg::QUO_W-1:0]         quot;
  logic [31:0]                       hp_mag;

  // Datapath values.
  logic signed [bhs_pkg::OP_A_W-1:0] d1, d2;
  logic signed [QW-1:0]              y1, y2;
  logic signed [bhs_pkg::ACC_W-1:0]  s_wide;
  logic signed [QW-1:0]              s_sat;
  logic signed [QW:0]                hp_wide;
  logic signed [QW-1:0]              hp_sat;
  logic signed [QW-1:0]              hist_new;
  logic signed [bhs_pkg::PROD_W-1:0] x_round;
  logic [23:0]                       result;
  logic                              in_accept;
  logic                              out_load;

  function automatic logic signed [bhs_pkg::OP_A_W-1:0] OP_A_W_EXT(
    input logic signed [bhs_pkg::COEF_W-1:0] v);
    OP_A_W_EXT = bhs_pkg::OP_A_W'(v);
  endfunction

  assign in_accept = in_tvalid && in_tready;
  assign last_pass = pass_r == bhs_pkg::PASS_W'(bhs_pkg::PASSES - 1);

  // Channels past the last one share the last history pair.
  assign ch_idx_nxt = (32'(in_tuser[0]) < bhs_pkg::CHANNELS) ?
                      CW'(in_tuser[0]) : CW'(bhs_pkg::CHANNELS - 1);

  // Exact coefficient differences and the current history pair.
  assign d1 = OP_A_W_EXT(coef_a2_r) - OP_A_W_EXT(coef_b1_r);
  assign d2 = OP_A_W_EXT(coef_a3_r) - OP_A_W_EXT(coef_b2_r);
  assign y1 = hist_one_r[ch_idx_r];
  assign y2 = hist_two_r[ch_idx_r];

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state_r)
      bhs_pkg::ST_GAIN: begin
        op_a = bhs_pkg::OP_A_W'(smp_r);
        op_b = $signed({16'd0, drive_gain_r});
      end
      bhs_pkg::ST_P1: begin
        op_a = OP_A_W_EXT(coef_a1_r);
        op_b = x_r;
      end
      bhs_pkg::ST_P2: begin
        op_a = d1;
        op_b = y1;
      end
      bhs_pkg::ST_P3: begin
        op_a = d2;
        op_b = y2;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Gain product rounded half up to Q8.24.
  assign x_round = (prod + bhs_pkg::PROD_W'(1 << (bhs_pkg::GAIN_SHIFT - 1)))
                   >>> bhs_pkg::GAIN_SHIFT;

  // Recursion output: round, saturate, form highpass and history value.
  assign s_wide = (acc + bhs_pkg::ACC_W'(1 << (bhs_pkg::SUM_SHIFT - 1)))
                  >>> bhs_pkg::SUM_SHIFT;

  always_comb begin
    if (s_wide > bhs_pkg::ACC_W'(32'sh7fffffff)) begin
      s_sat = 32'sh7fffffff;
    end else if (s_wide < -bhs_pkg::ACC_W'(33'sh080000000)) begin
      s_sat = 32'sh80000000;
    end else begin
      s_sat = QW'(s_wide);
    end
  end

  assign hp_wide = (QW + 1)'(x_r) - (QW + 1)'(s_sat);

  always_comb begin
    if (hp_wide > (QW + 1)'(32'sh7fffffff)) begin
      hp_sat = 32'sh7fffffff;
    end else if (hp_wide < -(QW + 1)'(33'sh080000000)) begin
      hp_sat = 32'sh80000000;
    end else begin
      hp_sat = QW'(hp_wide);
    end
  end

  always_comb begin
    if (s_sat > bhs_pkg::HIST_MAX) begin
      hist_new = bhs_pkg::HIST_MAX;
    end else if (s_sat < -bhs_pkg::HIST_MAX) begin
      hist_new = -bhs_pkg::HIST_MAX;
    end else begin
      hist_new = s_sat;
    end
  end

  // Magnitude for the soft clip; the most negative value maps to 2^31.
  assign hp_mag = hp_sat[QW-1] ? 32'(-hp_sat) : 32'(hp_sat);

  // Sign goes back on after the truncated quotient.
  assign result = hp_r[QW-1] ? 24'(-{1'b0, quot}) : 24'({1'b0, quot});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bhs_pkg::ST_IDLE: if (in_accept) state_nxt = bhs_pkg::ST_GAIN;
      bhs_pkg::ST_GAIN: state_nxt = bhs_pkg::ST_XCAP;
      bhs_pkg::ST_XCAP: state_nxt = bhs_pkg::ST_P1;
      bhs_pkg::ST_P1:   state_nxt = bhs_pkg::ST_P2;
      bhs_pkg::ST_P2:   state_nxt = bhs_pkg::ST_P3;
      bhs_pkg::ST_P3:   state_nxt = bhs_pkg::ST_SUM;
      bhs_pkg::ST_SUM:  state_nxt = bhs_pkg::ST_UPD;
      bhs_pkg::ST_UPD:  state_nxt = last_pass ? bhs_pkg::ST_DIV : bhs_pkg::ST_P1;
      bhs_pkg::ST_DIV:  if (div_done) state_nxt = bhs_pkg::ST_OUT;
      bhs_pkg::ST_OUT:  if (!out_tvalid_r || out_tready) state_nxt = bhs_pkg::ST_IDLE;
      default:          state_nxt = bhs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready        = state_r == bhs_pkg::ST_IDLE;
    mac_ctl.acc_load = state_r == bhs_pkg::ST_P2;
    mac_ctl.acc_add  = (state_r == bhs_pkg::ST_P3) || (state_r == bhs_pkg::ST_SUM);
    div_start        = (state_r == bhs_pkg::ST_UPD) && last_pass;
    out_load         = (state_r == bhs_pkg::ST_OUT) && (!out_tvalid_r || out_tready);
  end

  // Control registers: state, pass count, output valid, configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bhs_pkg::ST_IDLE;
      pass_r       <= '0;
      out_tvalid_r <= 1'b0;
      coef_a1_r    <= '0;
      coef_a2_r    <= '0;
      coef_a3_r    <= '0;
      coef_b1_r    <= '0;
      coef_b2_r    <= '0;
      drive_gain_r <= 16'd4096;
    end else begin
      state_r <= state_nxt;
      if (state_r == bhs_pkg::ST_XCAP) begin
        pass_r <= '0;
      end else if (state_r == bhs_pkg::ST_UPD) begin
        pass_r <= pass_r + 1'b1;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (bhs_pkg::cfg_reg_t'(cfg_index))
          bhs_pkg::REG_COEF_A1:    coef_a1_r    <= cfg_wdata;
          bhs_pkg::REG_COEF_A2:    coef_a2_r    <= cfg_wdata;
          bhs_pkg::REG_COEF_A3:    coef_a3_r    <= cfg_wdata;
          bhs_pkg::REG_COEF_B1:    coef_b1_r    <= cfg_wdata;
          bhs_pkg::REG_COEF_B2:    coef_b2_r    <= cfg_wdata;
          bhs_pkg::REG_DRIVE_GAIN: drive_gain_r <= cfg_wdata[bhs_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Channel history, cleared by reset and shifted once per pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bhs_pkg::CHANNELS; i++) begin
        hist_one_r[i] <= '0;
        hist_two_r[i] <= '0;
      end
    end else if (state_r == bhs_pkg::ST_UPD) begin
      hist_two_r[ch_idx_r] <= hist_one_r[ch_idx_r];
      hist_one_r[ch_idx_r] <= hist_new;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      smp_r    <= $signed(in_tdata);
      ch_in_r  <= in_tuser[0];
      ch_idx_r <= ch_idx_nxt;
    end
    if (state_r == bhs_pkg::ST_XCAP) begin
      x_r <= QW'(x_round);
    end
    if (state_r == bhs_pkg::ST_UPD) begin
      hp_r <= hp_sat;
    end
    if (out_load) begin
      out_tdata_r <= result;
      out_tuser_r <= ch_in_r;
    end
  end

  bhs_mac u_mac (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .ctl  (mac_ctl),
    .prod (prod),
    .acc  (acc)
  );

  bhs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (hp_mag),
    .done  (div_done),
    .quot  (quot)
  );

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

  // The divider only reports while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == bhs_pkg::ST_DIV)
    else $error("divider finished outside the division phase");

  // A soft-clipped result never reaches minus one.
  a_out_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != 24'h800000)
    else $error("soft clip produced full-scale output");

  // The stored history always stays within the clamp.
  a_hist_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bhs_pkg::ST_UPD |=>
      (hist_one_r[ch_idx_r] <= bhs_pkg::HIST_MAX) &&
      (hist_one_r[ch_idx_r] >= -bhs_pkg::HIST_MAX))
    else $error("history value outside the clamp");

  // An accepted item takes the input side busy at once.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("input ready while an item is being processed");

endmodule

### src/bhs_mac.sv
module bhs_mac (
  input  logic                                   clk,
  input  logic signed [bhs_pkg::OP_A_W-1:0]      op_a,
  input  logic signed [bhs_pkg::OP_B_W-1:0]      op_b,
  input  bhs_pkg::mac_ctl_t                      ctl,
  output logic signed [bhs_pkg::PROD_W-1:0]      prod,
  output logic signed [bhs_pkg::ACC_W-1:0]       acc
);

  logic signed [bhs_pkg::PROD_W-1:0] prod_r;
  logic signed [bhs_pkg::ACC_W-1:0]  acc_r;
  logic signed [bhs_pkg::ACC_W-1:0]  term;

  // The product of the previous cycle, floored to Q.32.
  assign term = bhs_pkg::ACC_W'(prod_r >>> bhs_pkg::PROD_SHIFT);

  // Registered multiplier followed by the accumulator.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (ctl.acc_load) begin
      acc_r <= term;
    end else if (ctl.acc_add) begin
      acc_r <= acc_r + term;
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

### src/bhs_div.sv
module bhs_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [31:0]                    mag,
  output logic                           done,
  output logic [bhs_pkg::QUO_W-1:0]      quot
);

  localparam int CNT_W = $clog2(bhs_pkg::QUO_W);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [32:0]                 rem_r;
  logic [32:0]                 den_r;
  logic [bhs_pkg::QUO_W-1:0]   quot_r;
  logic [33:0]                 trial;
  logic                        fits;

  // One restoring step: shift in a zero numerator bit and try the subtract.
  assign trial = {rem_r, 1'b0};
  assign fits  = trial >= {1'b0, den_r};

  // Control: the quotient is known to stay below 2^23, so 23 steps suffice.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(bhs_pkg::QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: divide mag * 2^23 by 2^24 + mag.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, mag};
      den_r  <= 33'(mag) + 33'h1000000;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? 33'(trial - {1'b0, den_r}) : 33'(trial);
      quot_r <= {quot_r[bhs_pkg::QUO_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

  // A new division is never started on top of one in flight.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule
